>>> src/wlfmc_pkg.sv
// Types and constants shared by the wall and line follow mode controller.
package wlfmc_pkg;

    // Mode codes, also used as published status codes
    localparam logic [1:0] MODE_IDLE  = 2'd0;
    localparam logic [1:0] MODE_WALL  = 2'd1;
    localparam logic [1:0] MODE_LINE  = 2'd2;
    localparam logic [1:0] MODE_PRINT = 2'd3;

    // Indicator colors
    localparam logic [1:0] COLOR_GREEN  = 2'd0;
    localparam logic [1:0] COLOR_RED    = 2'd1;
    localparam logic [1:0] COLOR_BLUE   = 2'd2;
    localparam logic [1:0] COLOR_ORANGE = 2'd3;

    // Configuration register indexes
    localparam logic [2:0] REG_NEAR_THR  = 3'd0;
    localparam logic [2:0] REG_PRESS_THR = 3'd1;
    localparam logic [2:0] REG_CLEAR_THR = 3'd2;
    localparam logic [2:0] REG_DARK_THR  = 3'd3;
    localparam logic [2:0] REG_WALL_GAIN = 3'd4;
    localparam logic [2:0] REG_LINE_GAIN = 3'd5;
    localparam logic [2:0] REG_CRUISE    = 3'd6;
    localparam logic [2:0] REG_FLOOR_OFS = 3'd7;

    // Register reset values
    localparam logic [15:0] RST_NEAR_THR  = 16'd4000;
    localparam logic [15:0] RST_PRESS_THR = 16'd40000;
    localparam logic [15:0] RST_CLEAR_THR = 16'd15000;
    localparam logic [15:0] RST_DARK_THR  = 16'd10000;
    localparam logic [15:0] RST_WALL_GAIN = 16'd11744;
    localparam logic [15:0] RST_LINE_GAIN = 16'd1678;
    localparam logic [15:0] RST_CRUISE    = 16'd26000 - 16'd22723;
    localparam logic [15:0] RST_FLOOR_OFS = 16'd26000;

    // Turn in place command, -2.0 in units of 2^-16
    localparam logic signed [23:0] HARD_TURN = -24'sd131072;

    // Turn saturation bounds at the product width
    localparam logic signed [34:0] ROT_MAX = 35'sd8388607;
    localparam logic signed [34:0] ROT_MIN = -35'sd8388608;

    // One proximity update
    typedef struct packed {
        logic [15:0] ring_0;
        logic [15:0] ring_1;
        logic [15:0] ring_2;
        logic [15:0] ring_3;
        logic [15:0] ring_4;
        logic [15:0] ring_5;
        logic [15:0] ring_6;
        logic [15:0] ring_7;
        logic [15:0] floor_left;
        logic [15:0] floor_right;
    } sensor_t;

    // One command result
    typedef struct packed {
        logic              motor_valid;
        logic [15:0]       translation;
        logic signed [23:0] rotation;
        logic [1:0]        mode;
        logic              led_valid;
        logic [1:0]        led_color;
        logic              status_valid;
        logic [1:0]        status_value;
    } command_t;

endpackage

>>> src/wall_line_follow_mode_controller_top.sv
// Wall and line follow mode controller: sensor register, decision logic, command register.
//
//  channel  | handshake                 | payload
//  ---------+---------------------------+-----------------------------
//  sensor   | sensor_valid / sensor_stall | sensor  (wlfmc_pkg::sensor_t)
//  cmd      | cmd_valid / cmd_stall       | cmd     (wlfmc_pkg::command_t)
//  config   | cfg_wr_en                   | cfg_index, cfg_data
//
// One transfer per cycle while cmd is not stalled; the path runs from the sensor register
// to the command register, through one 17x18 turn multiply between them.
// Reset clears both stage valids, sets mode to idle and loads the register defaults.
// A stall on cmd holds the command register; the sensor register keeps taking a
// transfer whenever its item can move forward in the same cycle.
module wall_line_follow_mode_controller_top
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 sensor_valid,
    output logic                 sensor_stall,
    input  wlfmc_pkg::sensor_t   sensor,
    output logic                 cmd_valid,
    input  logic                 cmd_stall,
    output wlfmc_pkg::command_t  cmd,
    input  logic                 cfg_wr_en,
    input  logic [2:0]           cfg_index,
    input  logic [15:0]          cfg_data
);

    // Configuration registers
    logic [15:0] near_thr_reg;
    logic [15:0] press_thr_reg;
    logic [15:0] clear_thr_reg;
    logic [15:0] dark_thr_reg;
    logic [15:0] wall_gain_reg;
    logic [15:0] line_gain_reg;
    logic [15:0] cruise_reg;
    logic [15:0] floor_ofs_reg;

    // Pipeline state
    logic                 s1_valid_reg;
    wlfmc_pkg::sensor_t   s1_data_reg;
    logic                 out_valid_reg;
    wlfmc_pkg::command_t  out_data_reg;
    logic [1:0]           mode_reg;
    logic [1:0]           mode_next;
    wlfmc_pkg::command_t  out_data_next;

    // Handshake control
    logic out_free;
    logic advance;

    // Decision terms
    logic stop_touch;
    logic wall_near;
    logic wall_exit;
    logic line_exit;
    logic press_line;
    logic press_print;

    // Turn datapath
    logic signed [17:0] wall_diff;
    logic signed [17:0] line_diff;
    logic signed [17:0] diff_sel;
    logic signed [16:0] gain_sel;
    logic signed [34:0] product;
    logic signed [34:0] shifted;
    logic signed [23:0] turn;

    assign out_free     = !out_valid_reg || !cmd_stall;
    assign advance      = s1_valid_reg && out_free;
    assign sensor_stall = s1_valid_reg && !out_free;
    assign cmd_valid    = out_valid_reg;
    assign cmd          = out_data_reg;

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            near_thr_reg  <= wlfmc_pkg::RST_NEAR_THR;
            press_thr_reg <= wlfmc_pkg::RST_PRESS_THR;
            clear_thr_reg <= wlfmc_pkg::RST_CLEAR_THR;
            dark_thr_reg  <= wlfmc_pkg::RST_DARK_THR;
            wall_gain_reg <= wlfmc_pkg::RST_WALL_GAIN;
            line_gain_reg <= wlfmc_pkg::RST_LINE_GAIN;
            cruise_reg    <= wlfmc_pkg::RST_CRUISE;
            floor_ofs_reg <= wlfmc_pkg::RST_FLOOR_OFS;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                wlfmc_pkg::REG_NEAR_THR:  near_thr_reg  <= cfg_data;
                wlfmc_pkg::REG_PRESS_THR: press_thr_reg <= cfg_data;
                wlfmc_pkg::REG_CLEAR_THR: clear_thr_reg <= cfg_data;
                wlfmc_pkg::REG_DARK_THR:  dark_thr_reg  <= cfg_data;
                wlfmc_pkg::REG_WALL_GAIN: wall_gain_reg <= cfg_data;
                wlfmc_pkg::REG_LINE_GAIN: line_gain_reg <= cfg_data;
                wlfmc_pkg::REG_CRUISE:    cruise_reg    <= cfg_data;
                wlfmc_pkg::REG_FLOOR_OFS: floor_ofs_reg <= cfg_data;
                default: ;
            endcase
        end
    end

    // Sensor register: load when empty or when its item moves on
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
        end
        else if (!s1_valid_reg || out_free)
        begin
            s1_valid_reg <= sensor_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (sensor_valid && !sensor_stall)
        begin
            s1_data_reg <= sensor;
        end
    end

    // Turn: gain times difference, round half up at 2^-8, saturate to 24 bits
    assign wall_diff = $signed({2'b00, s1_data_reg.ring_2}) - $signed({2'b00, s1_data_reg.ring_1});
    assign line_diff = $signed({2'b00, s1_data_reg.floor_right})
                     + $signed({2'b00, s1_data_reg.floor_left})
                     - $signed({2'b00, floor_ofs_reg});
    assign diff_sel  = (mode_reg == wlfmc_pkg::MODE_LINE) ? line_diff : wall_diff;
    assign gain_sel  = (mode_reg == wlfmc_pkg::MODE_LINE) ? $signed({1'b0, line_gain_reg})
                                                          : $signed({1'b0, wall_gain_reg});
    assign product   = gain_sel * diff_sel;
    assign shifted   = (product + 35'sd128) >>> 8;

    always_comb
    begin
        if (shifted > wlfmc_pkg::ROT_MAX)
            turn = wlfmc_pkg::ROT_MAX[23:0];
        else if (shifted < wlfmc_pkg::ROT_MIN)
            turn = wlfmc_pkg::ROT_MIN[23:0];
        else
            turn = shifted[23:0];
    end

    // Threshold tests
    assign stop_touch  = (s1_data_reg.ring_3 > press_thr_reg) && (s1_data_reg.ring_4 > press_thr_reg);
    assign press_line  = s1_data_reg.ring_2 > press_thr_reg;
    assign press_print = s1_data_reg.ring_6 > press_thr_reg;
    assign wall_near   = (s1_data_reg.ring_0 > near_thr_reg) || (s1_data_reg.ring_7 > near_thr_reg)
                      || (s1_data_reg.ring_1 > near_thr_reg);
    assign line_exit   = wall_near || (s1_data_reg.ring_6 > near_thr_reg);
    assign wall_exit   = (s1_data_reg.ring_0 < clear_thr_reg) && (s1_data_reg.ring_7 < clear_thr_reg)
                      && ((s1_data_reg.floor_left < dark_thr_reg)
                          || (s1_data_reg.floor_right < dark_thr_reg));

    // Mode rules; later events in a step override earlier ones
    always_comb
    begin
        mode_next     = mode_reg;
        out_data_next = '0;
        case (mode_reg)
            wlfmc_pkg::MODE_IDLE:
            begin
                out_data_next.motor_valid = 1'b1;
                if (press_line)
                begin
                    mode_next                  = wlfmc_pkg::MODE_LINE;
                    out_data_next.led_valid    = 1'b1;
                    out_data_next.led_color    = wlfmc_pkg::COLOR_GREEN;
                    out_data_next.status_valid = 1'b1;
                    out_data_next.status_value = wlfmc_pkg::MODE_LINE;
                end
                else if (press_print)
                begin
                    mode_next                  = wlfmc_pkg::MODE_PRINT;
                    out_data_next.led_valid    = 1'b1;
                    out_data_next.led_color    = wlfmc_pkg::COLOR_RED;
                    out_data_next.status_valid = 1'b1;
                    out_data_next.status_value = wlfmc_pkg::MODE_PRINT;
                end
            end
            wlfmc_pkg::MODE_WALL:
            begin
                if (stop_touch)
                begin
                    mode_next                  = wlfmc_pkg::MODE_IDLE;
                    out_data_next.led_valid    = 1'b1;
                    out_data_next.led_color    = wlfmc_pkg::COLOR_BLUE;
                    out_data_next.status_valid = 1'b1;
                    out_data_next.status_value = wlfmc_pkg::MODE_IDLE;
                end
                out_data_next.motor_valid = 1'b1;
                if (wall_near)
                begin
                    out_data_next.rotation = wlfmc_pkg::HARD_TURN;
                end
                else
                begin
                    out_data_next.translation = cruise_reg;
                    out_data_next.rotation    = turn;
                end
                if (wall_exit)
                begin
                    mode_next                  = wlfmc_pkg::MODE_LINE;
                    out_data_next.led_valid    = 1'b1;
                    out_data_next.led_color    = wlfmc_pkg::COLOR_GREEN;
                    out_data_next.status_valid = 1'b1;
                    out_data_next.status_value = wlfmc_pkg::MODE_LINE;
                end
            end
            wlfmc_pkg::MODE_LINE:
            begin
                if (stop_touch)
                begin
                    mode_next                  = wlfmc_pkg::MODE_IDLE;
                    out_data_next.led_valid    = 1'b1;
                    out_data_next.led_color    = wlfmc_pkg::COLOR_BLUE;
                    out_data_next.status_valid = 1'b1;
                    out_data_next.status_value = wlfmc_pkg::MODE_IDLE;
                end
                out_data_next.motor_valid = 1'b1;
                out_data_next.translation = cruise_reg;
                out_data_next.rotation    = turn;
                if (line_exit)
                begin
                    mode_next                  = wlfmc_pkg::MODE_WALL;
                    out_data_next.led_valid    = 1'b1;
                    out_data_next.led_color    = wlfmc_pkg::COLOR_ORANGE;
                    out_data_next.status_valid = 1'b1;
                    out_data_next.status_value = wlfmc_pkg::MODE_WALL;
                end
            end
            default:
            begin
                // print: no motor command, only the stop touch
                if (stop_touch)
                begin
                    mode_next                  = wlfmc_pkg::MODE_IDLE;
                    out_data_next.led_valid    = 1'b1;
                    out_data_next.led_color    = wlfmc_pkg::COLOR_BLUE;
                    out_data_next.status_valid = 1'b1;
                    out_data_next.status_value = wlfmc_pkg::MODE_IDLE;
                end
            end
        endcase
        out_data_next.mode = mode_next;
    end

    // Mode and command register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= wlfmc_pkg::MODE_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (advance)
            begin
                mode_reg <= mode_next;
            end
            if (out_free)
            begin
                out_valid_reg <= s1_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            out_data_reg <= out_data_next;
        end
    end

    // Mode moves only with a transfer into the command register
    assert property (@(posedge clk) disable iff (!rst_n)
        !advance |=> $stable(mode_reg))
        else $error("mode changed without a command transfer");

    // The reported mode is the mode the next item starts from
    assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> (cmd.mode == mode_reg))
        else $error("reported mode differs from held mode");

    // A published status always names the mode after the step
    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd_valid && cmd.status_valid) |-> (cmd.status_value == cmd.mode))
        else $error("status code does not match mode");

    // The sensor side stalls only with a full sensor register
    assert property (@(posedge clk) disable iff (!rst_n)
        sensor_stall |-> s1_valid_reg)
        else $error("stall with empty sensor register");

endmodule

>>> bench/wall_line_follow_mode_controller_top_test.sv
// Self-checking testbench for the wall and line follow mode controller.
module wall_line_follow_mode_controller_top_test;

    timeunit 1ns;
    timeprecision 1ps;

    localparam int QUIET_LIMIT  = 4000;  // cycles without any transfer before giving up
    localparam int HOLD_CYCLES  = 300;   // long output hold-off
    localparam int PHASE_ITEMS  = 380;
    localparam int DRAIN_CYCLES = 8;

    typedef enum logic {ROW_UPDATE, ROW_REG} row_kind_t;

    // One line of the directed table
    typedef struct {
        row_kind_t             kind;
        wlfmc_pkg::sensor_t    s;
        bit                    typed;
        wlfmc_pkg::command_t   want;
        logic [2:0]            idx;
        logic [15:0]           data;
    } row_t;

    logic                 clk          = 1'b0;
    logic                 rst_n        = 1'b0;
    logic                 sensor_valid = 1'b0;
    logic                 sensor_stall;
    wlfmc_pkg::sensor_t   sensor       = '0;
    logic                 cmd_valid;
    logic                 cmd_stall    = 1'b0;
    wlfmc_pkg::command_t  cmd;
    logic                 cfg_wr_en    = 1'b0;
    logic [2:0]           cfg_index    = wlfmc_pkg::REG_NEAR_THR;
    logic [15:0]          cfg_data     = '0;

    // Shadow of the block's registers and mode
    logic [15:0] reg_val [8];
    logic [1:0]  mode_q = wlfmc_pkg::MODE_IDLE;

    wlfmc_pkg::command_t pending_cmds [$];
    row_t                plan [$];

    int gap_pct      = 0;
    int stall_pct    = 0;
    bit hold_req     = 1'b0;
    int quiet_cycles = 0;
    int sent         = 0;
    int checked      = 0;
    int failures     = 0;
    int mode_hits [4] = '{0, 0, 0, 0};

    wall_line_follow_mode_controller_top DUT
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .sensor_valid (sensor_valid),
        .sensor_stall (sensor_stall),
        .sensor       (sensor),
        .cmd_valid    (cmd_valid),
        .cmd_stall    (cmd_stall),
        .cmd          (cmd),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic wlfmc_pkg::command_t make_cmd(input logic mv, input logic [15:0] tr,
                                                     input logic signed [23:0] rot,
                                                     input logic [1:0] md,
                                                     input logic lv, input logic [1:0] lc,
                                                     input logic sv, input logic [1:0] sc);
        wlfmc_pkg::command_t w;
        w.motor_valid  = mv;
        w.translation  = tr;
        w.rotation     = rot;
        w.mode         = md;
        w.led_valid    = lv;
        w.led_color    = lc;
        w.status_valid = sv;
        w.status_value = sc;
        return w;
    endfunction

    // Proportional turn: round half up after the 2^-8 scaling, then saturate
    function automatic logic signed [23:0] steer(input logic [15:0] gain, input longint diff);
        longint p;
        p = (longint'(gain) * diff + 128) >>> 8;
        if (p > wlfmc_pkg::ROT_MAX)
            p = wlfmc_pkg::ROT_MAX;
        else if (p < wlfmc_pkg::ROT_MIN)
            p = wlfmc_pkg::ROT_MIN;
        return p[23:0];
    endfunction

    // Expected command for one sensor update; advances the shadow mode
    function automatic wlfmc_pkg::command_t next_command(input wlfmc_pkg::sensor_t s);
        wlfmc_pkg::command_t c;
        logic     stop_hit;
        logic [15:0] nthr, pthr, cthr, dthr;
        nthr = reg_val[wlfmc_pkg::REG_NEAR_THR];
        pthr = reg_val[wlfmc_pkg::REG_PRESS_THR];
        cthr = reg_val[wlfmc_pkg::REG_CLEAR_THR];
        dthr = reg_val[wlfmc_pkg::REG_DARK_THR];
        c = '0;
        stop_hit = (s.ring_3 > pthr) && (s.ring_4 > pthr);
        case (mode_q)
            wlfmc_pkg::MODE_IDLE:
            begin
                c.motor_valid = 1'b1;
                if (s.ring_2 > pthr)
                begin
                    c.led_valid = 1'b1; c.led_color = wlfmc_pkg::COLOR_GREEN;
                    mode_q = wlfmc_pkg::MODE_LINE;
                    c.status_valid = 1'b1; c.status_value = wlfmc_pkg::MODE_LINE;
                end
                else if (s.ring_6 > pthr)
                begin
                    c.led_valid = 1'b1; c.led_color = wlfmc_pkg::COLOR_RED;
                    mode_q = wlfmc_pkg::MODE_PRINT;
                    c.status_valid = 1'b1; c.status_value = wlfmc_pkg::MODE_PRINT;
                end
            end
            wlfmc_pkg::MODE_WALL:
            begin
                if (stop_hit)
                begin
                    c.led_valid = 1'b1; c.led_color = wlfmc_pkg::COLOR_BLUE;
                    mode_q = wlfmc_pkg::MODE_IDLE;
                    c.status_valid = 1'b1; c.status_value = wlfmc_pkg::MODE_IDLE;
                end
                c.motor_valid = 1'b1;
                if (s.ring_0 > nthr || s.ring_7 > nthr || s.ring_1 > nthr)
                begin
                    c.translation = '0;
                    c.rotation    = wlfmc_pkg::HARD_TURN;
                end
                else
                begin
                    c.translation = reg_val[wlfmc_pkg::REG_CRUISE];
                    c.rotation    = steer(reg_val[wlfmc_pkg::REG_WALL_GAIN],
                                          longint'(s.ring_2) - longint'(s.ring_1));
                end
                if (s.ring_0 < cthr && s.ring_7 < cthr &&
                    (s.floor_left < dthr || s.floor_right < dthr))
                begin
                    mode_q = wlfmc_pkg::MODE_LINE;
                    c.status_valid = 1'b1; c.status_value = wlfmc_pkg::MODE_LINE;
                    c.led_valid = 1'b1; c.led_color = wlfmc_pkg::COLOR_GREEN;
                end
            end
            wlfmc_pkg::MODE_LINE:
            begin
                if (stop_hit)
                begin
                    c.led_valid = 1'b1; c.led_color = wlfmc_pkg::COLOR_BLUE;
                    mode_q = wlfmc_pkg::MODE_IDLE;
                    c.status_valid = 1'b1; c.status_value = wlfmc_pkg::MODE_IDLE;
                end
                c.motor_valid = 1'b1;
                c.translation = reg_val[wlfmc_pkg::REG_CRUISE];
                c.rotation    = steer(reg_val[wlfmc_pkg::REG_LINE_GAIN],
                                      longint'(s.floor_right) + longint'(s.floor_left) -
                                      longint'(reg_val[wlfmc_pkg::REG_FLOOR_OFS]));
                if (s.ring_0 > nthr || s.ring_7 > nthr || s.ring_6 > nthr || s.ring_1 > nthr)
                begin
                    mode_q = wlfmc_pkg::MODE_WALL;
                    c.status_valid = 1'b1; c.status_value = wlfmc_pkg::MODE_WALL;
                    c.led_valid = 1'b1; c.led_color = wlfmc_pkg::COLOR_ORANGE;
                end
            end
            default:
            begin
                // print: touch to stop, but no motor command
                if (stop_hit)
                begin
                    c.led_valid = 1'b1; c.led_color = wlfmc_pkg::COLOR_BLUE;
                    mode_q = wlfmc_pkg::MODE_IDLE;
                    c.status_valid = 1'b1; c.status_value = wlfmc_pkg::MODE_IDLE;
                end
            end
        endcase
        c.mode = mode_q;
        mode_hits[mode_q]++;
        return c;
    endfunction

    // Sensor reading biased toward the thresholds and the ends of the range
    function automatic logic [15:0] draw_reading();
        int v;
        logic [15:0] thr;
        case ($urandom_range(9))
            0: return 16'h0000;
            1: return 16'hFFFF;
            2, 3, 4: return 16'($urandom_range(65535));
            5, 6: return 16'($urandom_range(3000));
            default:
            begin
                case ($urandom_range(3))
                    0: thr = reg_val[wlfmc_pkg::REG_NEAR_THR];
                    1: thr = reg_val[wlfmc_pkg::REG_PRESS_THR];
                    2: thr = reg_val[wlfmc_pkg::REG_CLEAR_THR];
                    default: thr = reg_val[wlfmc_pkg::REG_DARK_THR];
                endcase
                v = int'(thr) + int'($urandom_range(4)) - 2;
                if (v < 0)
                    v = 0;
                else if (v > 65535)
                    v = 65535;
                return v[15:0];
            end
        endcase
    endfunction

    function automatic wlfmc_pkg::sensor_t draw_update();
        wlfmc_pkg::sensor_t s;
        int v;
        s.ring_0      = draw_reading();
        s.ring_1      = draw_reading();
        s.ring_2      = draw_reading();
        s.ring_3      = draw_reading();
        s.ring_4      = draw_reading();
        s.ring_5      = draw_reading();
        s.ring_6      = draw_reading();
        s.ring_7      = draw_reading();
        s.floor_left  = draw_reading();
        s.floor_right = draw_reading();
        // sometimes put the floor difference right around zero to hit the rounding
        if ($urandom_range(3) == 0)
        begin
            v = int'(reg_val[wlfmc_pkg::REG_FLOOR_OFS]) - int'(s.floor_left)
                + int'($urandom_range(600)) - 300;
            if (v < 0)
                v = 0;
            else if (v > 65535)
                v = 65535;
            s.floor_right = v[15:0];
        end
        return s;
    endfunction

    // Offer one update until it transfers, then queue its expected command
    task automatic send_update(input wlfmc_pkg::sensor_t s, input bit typed,
                               input wlfmc_pkg::command_t want);
        wlfmc_pkg::command_t c;
        while ($urandom_range(99) < gap_pct)
        begin
            sensor_valid <= 1'b0;
            @(posedge clk);
        end
        sensor_valid <= 1'b1;
        sensor       <= s;
        do
            @(posedge clk);
        while (sensor_stall);
        c = next_command(s);
        pending_cmds.push_back(typed ? want : c);
        sent++;
    endtask

    // Register write, only once the block has drained
    task automatic write_reg(input logic [2:0] idx, input logic [15:0] data);
        sensor_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        reg_val[idx] = data;
        @(posedge clk);
    endtask

    task automatic load_settings(input logic [15:0] nthr, input logic [15:0] pthr,
                                 input logic [15:0] cthr, input logic [15:0] dthr,
                                 input logic [15:0] wg, input logic [15:0] lg,
                                 input logic [15:0] cs, input logic [15:0] fo);
        write_reg(wlfmc_pkg::REG_NEAR_THR, nthr);
        write_reg(wlfmc_pkg::REG_PRESS_THR, pthr);
        write_reg(wlfmc_pkg::REG_CLEAR_THR, cthr);
        write_reg(wlfmc_pkg::REG_DARK_THR, dthr);
        write_reg(wlfmc_pkg::REG_WALL_GAIN, wg);
        write_reg(wlfmc_pkg::REG_LINE_GAIN, lg);
        write_reg(wlfmc_pkg::REG_CRUISE, cs);
        write_reg(wlfmc_pkg::REG_FLOOR_OFS, fo);
    endtask

    task automatic add_update(input wlfmc_pkg::sensor_t s);
        row_t r;
        r = '{ROW_UPDATE, s, 1'b0, '0, wlfmc_pkg::REG_NEAR_THR, '0};
        plan.push_back(r);
    endtask

    task automatic add_typed(input wlfmc_pkg::sensor_t s, input wlfmc_pkg::command_t w);
        row_t r;
        r = '{ROW_UPDATE, s, 1'b1, w, wlfmc_pkg::REG_NEAR_THR, '0};
        plan.push_back(r);
    endtask

    task automatic add_reg(input logic [2:0] idx, input logic [15:0] data);
        row_t r;
        r = '{ROW_REG, '0, 1'b0, '0, idx, data};
        plan.push_back(r);
    endtask

    // Directed table: mode entries and exits, thresholds, saturation, register extremes
    task automatic build_plan();
        wlfmc_pkg::sensor_t v;
        // idle, nothing pressed
        v = '0;
        add_typed(v, make_cmd(1, 0, 0, wlfmc_pkg::MODE_IDLE,
                              0, wlfmc_pkg::COLOR_GREEN, 0, wlfmc_pkg::MODE_IDLE));
        // ring 6 press enters print
        v = '0; v.ring_6 = '1;
        add_typed(v, make_cmd(1, 0, 0, wlfmc_pkg::MODE_PRINT,
                              1, wlfmc_pkg::COLOR_RED, 1, wlfmc_pkg::MODE_PRINT));
        // stop touch from print: no motor command
        v = '1;
        add_typed(v, make_cmd(0, 0, 0, wlfmc_pkg::MODE_IDLE,
                              1, wlfmc_pkg::COLOR_BLUE, 1, wlfmc_pkg::MODE_IDLE));
        // ring 2 wins over ring 6
        v = '0; v.ring_2 = '1; v.ring_6 = '1;
        add_typed(v, make_cmd(1, 0, 0, wlfmc_pkg::MODE_LINE,
                              1, wlfmc_pkg::COLOR_GREEN, 1, wlfmc_pkg::MODE_LINE));
        // line steering: both floors full, both empty, just under zero
        v = '0; v.floor_left = '1; v.floor_right = '1;
        add_update(v);
        v = '0;
        add_update(v);
        v = '0; v.floor_left = 16'd25999;
        add_update(v);
        // ring 0 at near threshold is not near
        v = '0; v.ring_0 = 16'd4000; v.floor_left = 16'd13000; v.floor_right = 16'd13000;
        add_update(v);
        // ring 1 just above near: into wall follow
        v = '0; v.ring_1 = 16'd4001; v.floor_left = 16'd13000; v.floor_right = 16'd13000;
        add_update(v);
        // obstacle ahead: turn in place
        v = '0; v.ring_0 = '1;
        add_typed(v, make_cmd(1, 0, wlfmc_pkg::HARD_TURN, wlfmc_pkg::MODE_WALL,
                              0, wlfmc_pkg::COLOR_GREEN, 0, wlfmc_pkg::MODE_IDLE));
        // wall steering at both ends of the difference
        v = '0; v.ring_2 = '1; v.floor_left = '1; v.floor_right = '1;
        add_update(v);
        v = '0; v.ring_1 = 16'd4000; v.floor_left = '1; v.floor_right = '1;
        add_update(v);
        // stop touch in wall follow still reports the follow command
        v = '0; v.ring_3 = '1; v.ring_4 = '1; v.floor_left = '1; v.floor_right = '1;
        add_typed(v, make_cmd(1, wlfmc_pkg::RST_CRUISE, 0, wlfmc_pkg::MODE_IDLE,
                              1, wlfmc_pkg::COLOR_BLUE, 1, wlfmc_pkg::MODE_IDLE));
        v = '0; v.ring_2 = '1;
        add_typed(v, make_cmd(1, 0, 0, wlfmc_pkg::MODE_LINE,
                              1, wlfmc_pkg::COLOR_GREEN, 1, wlfmc_pkg::MODE_LINE));
        // stop touch and line exit in one step: the exit wins
        v = '0; v.ring_1 = '1; v.ring_3 = '1; v.ring_4 = '1; v.floor_left = 16'd26000;
        add_typed(v, make_cmd(1, wlfmc_pkg::RST_CRUISE, 0, wlfmc_pkg::MODE_WALL,
                              1, wlfmc_pkg::COLOR_ORANGE, 1, wlfmc_pkg::MODE_WALL));
        // stop touch and wall exit in one step
        v = '0; v.ring_3 = '1; v.ring_4 = '1; v.floor_right = '1;
        add_typed(v, make_cmd(1, wlfmc_pkg::RST_CRUISE, 0, wlfmc_pkg::MODE_LINE,
                              1, wlfmc_pkg::COLOR_GREEN, 1, wlfmc_pkg::MODE_LINE));
        // largest gains and speed: turn saturates both ways
        add_reg(wlfmc_pkg::REG_WALL_GAIN, '1);
        add_reg(wlfmc_pkg::REG_LINE_GAIN, '1);
        add_reg(wlfmc_pkg::REG_CRUISE, '1);
        add_reg(wlfmc_pkg::REG_FLOOR_OFS, '0);
        v = '0; v.floor_left = '1; v.floor_right = '1;
        add_typed(v, make_cmd(1, '1, wlfmc_pkg::ROT_MAX[23:0], wlfmc_pkg::MODE_LINE,
                              0, wlfmc_pkg::COLOR_GREEN, 0, wlfmc_pkg::MODE_IDLE));
        add_reg(wlfmc_pkg::REG_FLOOR_OFS, '1);
        v = '0;
        add_typed(v, make_cmd(1, '1, wlfmc_pkg::ROT_MIN[23:0], wlfmc_pkg::MODE_LINE,
                              0, wlfmc_pkg::COLOR_GREEN, 0, wlfmc_pkg::MODE_IDLE));
        v = '0; v.ring_7 = '1;
        add_update(v);
        v = '0; v.ring_2 = '1; v.floor_left = '1; v.floor_right = '1;
        add_typed(v, make_cmd(1, '1, wlfmc_pkg::ROT_MAX[23:0], wlfmc_pkg::MODE_WALL,
                              0, wlfmc_pkg::COLOR_GREEN, 0, wlfmc_pkg::MODE_IDLE));
        // thresholds at their ends
        add_reg(wlfmc_pkg::REG_NEAR_THR, '1);
        add_reg(wlfmc_pkg::REG_PRESS_THR, '0);
        add_reg(wlfmc_pkg::REG_CLEAR_THR, '1);
        add_reg(wlfmc_pkg::REG_DARK_THR, '0);
        v = '0; v.ring_0 = '1; v.ring_1 = '1; v.ring_3 = 16'd1; v.ring_4 = 16'd1;
        add_update(v);
        v = '0;
        add_typed(v, make_cmd(1, 0, 0, wlfmc_pkg::MODE_IDLE,
                              0, wlfmc_pkg::COLOR_GREEN, 0, wlfmc_pkg::MODE_IDLE));
        v = '0; v.ring_6 = 16'd1;
        add_typed(v, make_cmd(1, 0, 0, wlfmc_pkg::MODE_PRINT,
                              1, wlfmc_pkg::COLOR_RED, 1, wlfmc_pkg::MODE_PRINT));
        v = '0; v.ring_3 = 16'd1;
        add_typed(v, make_cmd(0, 0, 0, wlfmc_pkg::MODE_PRINT,
                              0, wlfmc_pkg::COLOR_GREEN, 0, wlfmc_pkg::MODE_IDLE));
        v = '0; v.ring_3 = 16'd1; v.ring_4 = 16'd1;
        add_typed(v, make_cmd(0, 0, 0, wlfmc_pkg::MODE_IDLE,
                              1, wlfmc_pkg::COLOR_BLUE, 1, wlfmc_pkg::MODE_IDLE));
    endtask

    // Output stall: random by phase, or one long hold-off on request
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_req)
            begin
                cmd_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                hold_req = 1'b0;
            end
            else
                cmd_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    // Result checker and watchdog
    always @(posedge clk)
    begin
        wlfmc_pkg::command_t w;
        bit bad;
        if ((sensor_valid && !sensor_stall) || (cmd_valid && !cmd_stall) || cfg_wr_en)
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT)
        begin
            $display("timeout: no transfer for %0d cycles, %0d results outstanding",
                     quiet_cycles, pending_cmds.size());
            $display("CHECKS FAILED");
            $finish;
        end
        else if (rst_n && cmd_valid && !cmd_stall)
        begin
            if (pending_cmds.size() == 0)
            begin
                if (failures < 10)
                    $display("unexpected command transfer: mode=%0d", cmd.mode);
                failures++;
            end
            else
            begin
                w = pending_cmds.pop_front();
                checked++;
                bad = (cmd.motor_valid !== w.motor_valid) ||
                      (cmd.translation !== w.translation) ||
                      (cmd.rotation !== w.rotation) ||
                      (cmd.mode !== w.mode) ||
                      (cmd.led_valid !== w.led_valid) ||
                      (cmd.led_color !== w.led_color) ||
                      (cmd.status_valid !== w.status_valid) ||
                      (cmd.status_value !== w.status_value);
                if (bad)
                begin
                    if (failures < 10)
                    begin
                        $display({"result %0d expected: mv=%0b tr=%0d rot=%0d mode=%0d",
                                  " led=%0b/%0d sts=%0b/%0d"},
                                 checked, w.motor_valid, w.translation, w.rotation, w.mode,
                                 w.led_valid, w.led_color, w.status_valid, w.status_value);
                        $display({"result %0d actual:   mv=%0b tr=%0d rot=%0d mode=%0d",
                                  " led=%0b/%0d sts=%0b/%0d"},
                                 checked, cmd.motor_valid, cmd.translation, cmd.rotation,
                                 cmd.mode, cmd.led_valid, cmd.led_color, cmd.status_valid,
                                 cmd.status_value);
                    end
                    failures++;
                end
            end
        end
    end

    // Main sequence
    initial
    begin
        reg_val[wlfmc_pkg::REG_NEAR_THR]  = wlfmc_pkg::RST_NEAR_THR;
        reg_val[wlfmc_pkg::REG_PRESS_THR] = wlfmc_pkg::RST_PRESS_THR;
        reg_val[wlfmc_pkg::REG_CLEAR_THR] = wlfmc_pkg::RST_CLEAR_THR;
        reg_val[wlfmc_pkg::REG_DARK_THR]  = wlfmc_pkg::RST_DARK_THR;
        reg_val[wlfmc_pkg::REG_WALL_GAIN] = wlfmc_pkg::RST_WALL_GAIN;
        reg_val[wlfmc_pkg::REG_LINE_GAIN] = wlfmc_pkg::RST_LINE_GAIN;
        reg_val[wlfmc_pkg::REG_CRUISE]    = wlfmc_pkg::RST_CRUISE;
        reg_val[wlfmc_pkg::REG_FLOOR_OFS] = wlfmc_pkg::RST_FLOOR_OFS;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed table, with light idling on both sides
        gap_pct   = 14;
        stall_pct = 14;
        build_plan();
        foreach (plan[i])
        begin
            if (plan[i].kind == ROW_REG)
                write_reg(plan[i].idx, plan[i].data);
            else
                send_update(plan[i].s, plan[i].typed, plan[i].want);
        end

        // random phases, each with its own register setting and idling mix
        for (int p = 0; p < 5; p++)
        begin
            case (p)
                0: load_settings(wlfmc_pkg::RST_NEAR_THR, wlfmc_pkg::RST_PRESS_THR,
                                 wlfmc_pkg::RST_CLEAR_THR, wlfmc_pkg::RST_DARK_THR,
                                 wlfmc_pkg::RST_WALL_GAIN, wlfmc_pkg::RST_LINE_GAIN,
                                 wlfmc_pkg::RST_CRUISE, wlfmc_pkg::RST_FLOOR_OFS);
                1: load_settings(16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                 16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                 16'($urandom_range(65535)), 16'($urandom_range(65535)));
                2: load_settings('0, '0, '0, '0, '1, '1, '1, '0);
                3: load_settings('1, '1, '1, '1, '0, '0, '0, '1);
                default: load_settings(16'($urandom_range(20000)),
                                       16'(30000 + $urandom_range(30000)),
                                       16'($urandom_range(30000)), 16'($urandom_range(30000)),
                                       16'($urandom_range(65535)), 16'($urandom_range(65535)),
                                       16'($urandom_range(65535)), 16'($urandom_range(65535)));
            endcase
            case (p)
                0: begin gap_pct = 0;  stall_pct = 0;  hold_req = 1'b1; end
                1: begin gap_pct = 50; stall_pct = 0;  end
                2: begin gap_pct = 0;  stall_pct = 50; end
                3: begin gap_pct = 14; stall_pct = 14; end
                default: begin gap_pct = 0; stall_pct = 0; end
            endcase
            repeat (PHASE_ITEMS)
                send_update(draw_update(), 1'b0, '0);
        end

        // drain, then allow for any stray result
        sensor_valid <= 1'b0;
        while (pending_cmds.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (pending_cmds.size() != 0)
        begin
            $display("%0d expected results never arrived", pending_cmds.size());
            failures += pending_cmds.size();
        end
        $display({"Covered %0d sensor updates: directed table plus five register settings,",
                  " four idling mixes and one long output hold-off."}, sent);
        $display({"Results checked %0d, mismatches %0d;",
                  " steps ending idle/wall/line/print: %0d/%0d/%0d/%0d."},
                 checked, failures, mode_hits[wlfmc_pkg::MODE_IDLE],
                 mode_hits[wlfmc_pkg::MODE_WALL], mode_hits[wlfmc_pkg::MODE_LINE],
                 mode_hits[wlfmc_pkg::MODE_PRINT]);
        if (failures == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
